[rtl/pfla_pkg.sv]
package pfla_pkg;

	localparam int PAGE_COUNT = 32768;
	localparam int PAGE_W     = $clog2(PAGE_COUNT);
	localparam int CNT_W      = $clog2(PAGE_COUNT + 1);
	localparam int FIRST_W    = 15;
	localparam int END_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_RANGE   = 3'd1,
		STAT_DOUBLE  = 3'd2,
		STAT_EMPTY   = 3'd3,
		STAT_COUNTED = 3'd4
	} status_t;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_PAGE   = 1'b1;

	// One word per page: allocation bit and the link to the next free page.
	typedef struct packed {
		logic              counted;
		logic [PAGE_W-1:0] link;
	} entry_t;

endpackage

[rtl/pfla_cfg_if.sv]
interface pfla_cfg_if
	import pfla_pkg::*;
	;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/pfla_cmd_if.sv]
interface pfla_cmd_if
	import pfla_pkg::*;
	;
	logic              valid;
	logic              ready;
	opcode_t           opcode;
	logic [PAGE_W-1:0] page_in;

	modport source (output valid, output opcode, output page_in, input ready);
	modport sink (input valid, input opcode, input page_in, output ready);
endinterface

[rtl/pfla_rsp_if.sv]
interface pfla_rsp_if
	import pfla_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [PAGE_W-1:0] page_out;
	status_t           status;
	logic [CNT_W-1:0]  free_pages;

	modport source (output valid, output page_out, output status, output free_pages,
		input ready);
	modport sink (input valid, input page_out, input status, input free_pages,
		output ready);
endinterface

[rtl/page_free_list_allocator_core.sv]
// Page frame pool kept as a LIFO free list with one allocation bit per page.
// Channels: cfg writes first_page (index 0) and end_page (index 1); it is always
// ready and must only be used while no command is in flight. cmd carries an
// opcode (init, allocate, free, no-op) and the page to free. rsp returns one
// beat per command: allocated page, status and the free-page count after it.
// Allocate, free and no-op read the page memory at the accepting edge; in the
// update stage (S_EXEC) the entry is updated and written back and the result
// register is loaded. The next command is taken once the block is back in idle,
// so no new command is taken before the last one is through. Init walks the
// pages from first_page up to, not including, bound, writing one page per cycle,
// then loads the result register, bound being the smaller of end_page and the pool size.
// After reset the block runs a clearing pass over all 32768 memory words, one
// per cycle, with cmd.ready low; configuration writes are taken meanwhile.
// The result sits in an output register. While the receiver stalls, the block
// holds the finished command in its update stage and accepts no new command.
module page_free_list_allocator_core
	import pfla_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	pfla_cfg_if.sink  cfg,
	pfla_cmd_if.sink  cmd,
	pfla_rsp_if.source rsp
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK,
		S_EXEC
	} state_t;

	state_t              state_q;
	logic [FIRST_W-1:0]  first_q;
	logic [END_W-1:0]    end_q;
	logic [PAGE_W-1:0]   head_q;
	logic                nonempty_q;
	logic [CNT_W-1:0]    free_q;
	logic [CNT_W-1:0]    walk_q;
	opcode_t             op_q;
	logic [PAGE_W-1:0]   pg_q;

	entry_t              mem [PAGE_COUNT];
	entry_t              rd_s1;
	logic                rd_en;
	logic [PAGE_W-1:0]   rd_addr;
	logic                mem_we;
	logic [PAGE_W-1:0]   mem_waddr;
	entry_t              mem_wdata;

	logic                rsp_valid_q;
	logic [PAGE_W-1:0]   rsp_page_q;
	status_t             rsp_status_q;
	logic [CNT_W-1:0]    rsp_free_q;

	logic [CNT_W-1:0]    bound;
	logic                walk_more;
	logic                range_fail;
	logic                out_free;
	logic                cmd_acc;
	logic                alloc_ok;
	logic                free_ok;
	logic [PAGE_W-1:0]   res_page;
	status_t             res_status;
	logic [CNT_W-1:0]    res_free;

	assign cfg.ready = 1'b1;
	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	assign rsp.valid      = rsp_valid_q;
	assign rsp.page_out   = rsp_page_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.free_pages = rsp_free_q;

	assign bound = (end_q < CNT_W'(PAGE_COUNT)) ? CNT_W'(end_q) : CNT_W'(PAGE_COUNT);
	assign walk_more  = walk_q < bound;
	assign range_fail = (pg_q < first_q) || (CNT_W'(pg_q) >= bound);
	assign alloc_ok   = nonempty_q && !rd_s1.counted;
	assign free_ok    = !range_fail && rd_s1.counted;

	// The read is launched at the accepting edge; data is used in S_EXEC.
	assign rd_en   = cmd_acc;
	assign rd_addr = (cmd.opcode == OP_ALLOC) ? head_q : cmd.page_in;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = walk_q[PAGE_W-1:0];
		mem_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_WALK: begin
				mem_we         = walk_more;
				mem_wdata.link = head_q;
			end
			S_EXEC: begin
				if (out_free && op_q == OP_ALLOC && alloc_ok) begin
					mem_we            = 1'b1;
					mem_waddr         = head_q;
					mem_wdata.counted = 1'b1;
					mem_wdata.link    = rd_s1.link;
				end else if (out_free && op_q == OP_FREE && free_ok) begin
					mem_we         = 1'b1;
					mem_waddr      = pg_q;
					mem_wdata.link = head_q;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		res_page   = '0;
		res_status = STAT_OK;
		res_free   = free_q;
		case (op_q)
			OP_ALLOC: begin
				if (!nonempty_q) begin
					res_status = STAT_EMPTY;
				end else if (rd_s1.counted) begin
					res_status = STAT_COUNTED;
				end else begin
					res_page = head_q;
					res_free = free_q - 1'b1;
				end
			end
			OP_FREE: begin
				if (range_fail) begin
					res_status = STAT_RANGE;
				end else if (!rd_s1.counted) begin
					res_status = STAT_DOUBLE;
				end else begin
					res_free = free_q + 1'b1;
				end
			end
			default: begin
				res_status = STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			end_q   <= END_W'(PAGE_COUNT);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_FIRST_PAGE: first_q <= cfg.data[FIRST_W-1:0];
				CFG_END_PAGE:   end_q   <= cfg.data[END_W-1:0];
				default:        first_q <= first_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			head_q       <= '0;
			nonempty_q   <= 1'b0;
			free_q       <= '0;
			walk_q       <= '0;
			op_q         <= OP_NOP;
			pg_q         <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_page_q   <= '0;
			rsp_status_q <= STAT_OK;
			rsp_free_q   <= '0;
		end else begin
			if (state_q == S_EXEC && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					walk_q <= walk_q + 1'b1;
					if (walk_q == CNT_W'(PAGE_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_acc) begin
						op_q <= cmd.opcode;
						pg_q <= cmd.page_in;
						if (cmd.opcode == OP_INIT) begin
							head_q     <= '0;
							nonempty_q <= 1'b0;
							free_q     <= '0;
							walk_q     <= CNT_W'(first_q);
							state_q    <= S_WALK;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_WALK: begin
					if (walk_more) begin
						head_q     <= walk_q[PAGE_W-1:0];
						nonempty_q <= 1'b1;
						free_q     <= free_q + 1'b1;
						walk_q     <= walk_q + 1'b1;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						rsp_page_q   <= res_page;
						rsp_status_q <= res_status;
						rsp_free_q   <= res_free;
						state_q      <= S_IDLE;
						if (op_q == OP_ALLOC && alloc_ok) begin
							free_q     <= free_q - 1'b1;
							nonempty_q <= (free_q != CNT_W'(1));
							head_q     <= (free_q != CNT_W'(1)) ? rd_s1.link : '0;
						end else if (op_q == OP_FREE && free_ok) begin
							free_q     <= free_q + 1'b1;
							nonempty_q <= 1'b1;
							head_q     <= pg_q;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= CNT_W'(PAGE_COUNT))
		else $error("free-page count exceeds the pool size");

	a_nonempty_match: assert property (@(posedge clk) disable iff (!arst_n)
		nonempty_q == (free_q != '0))
		else $error("list nonempty flag disagrees with the free-page count");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> !cmd.ready)
		else $error("command accepted while another one is in flight");

	a_rsp_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == S_EXEC))
		else $error("response beat raised outside the update stage");
`endif

endmodule

[sim/pfla_pool_checker.sv]
`timescale 1ns / 1ps

module pfla_pool_checker
	import pfla_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	pfla_cfg_if         cfg,
	pfla_cmd_if         cmd,
	pfla_rsp_if         rsp,
	output int unsigned errors,
	output int unsigned outstanding
);

	typedef struct packed {
		logic [PAGE_W-1:0] page_out;
		status_t           status;
		logic [CNT_W-1:0]  free_pages;
	} pool_result_t;

	// Shadow copy of the pool: allocation bits, free-list links and head.
	bit                page_taken [PAGE_COUNT];
	logic [PAGE_W-1:0] page_link  [PAGE_COUNT];
	int unsigned       head_page;
	bit                list_live;
	int unsigned       free_count;
	int unsigned       cfg_first;
	int unsigned       cfg_end;
	int unsigned       rsp_beats;

	pool_result_t expected_rsp_q [$];

	function automatic int unsigned walk_limit();
		return (cfg_end < PAGE_COUNT) ? cfg_end : PAGE_COUNT;
	endfunction

	function automatic void push_free(int unsigned pg);
		page_link[pg] = PAGE_W'(head_page);
		head_page = pg;
		list_live = 1'b1;
		free_count++;
	endfunction

	function automatic pool_result_t apply_pool_op(opcode_t op, int unsigned pg);
		pool_result_t res;
		int unsigned  p;
		res.page_out = '0;
		res.status   = STAT_OK;
		case (op)
			OP_INIT: begin
				head_page  = 0;
				list_live  = 1'b0;
				free_count = 0;
				for (p = cfg_first; p < walk_limit(); p++) begin
					page_taken[p] = 1'b0;
					push_free(p);
				end
			end
			OP_ALLOC: begin
				if (!list_live) begin
					res.status = STAT_EMPTY;
				end else if (page_taken[head_page]) begin
					res.status = STAT_COUNTED;
				end else begin
					res.page_out = PAGE_W'(head_page);
					page_taken[head_page] = 1'b1;
					free_count--;
					list_live = (free_count != 0);
					head_page = list_live ? int'(page_link[head_page]) : 0;
				end
			end
			OP_FREE: begin
				if (pg < cfg_first || pg >= walk_limit()) begin
					res.status = STAT_RANGE;
				end else if (!page_taken[pg]) begin
					res.status = STAT_DOUBLE;
				end else begin
					page_taken[pg] = 1'b0;
					push_free(pg);
				end
			end
			default: ;
		endcase
		res.free_pages = CNT_W'(free_count);
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t: mismatch: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pool_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < PAGE_COUNT; i++) begin
				page_taken[i] = 1'b0;
				page_link[i]  = '0;
			end
			head_page  = 0;
			list_live  = 1'b0;
			free_count = 0;
			cfg_first  = 0;
			cfg_end    = PAGE_COUNT;
			rsp_beats  = 0;
			expected_rsp_q.delete();
			outstanding <= 0;
		end else begin
			// The response is matched before this edge's command is predicted, so a
			// beat can never be paired with the command accepted on the same edge.
			if (rsp.valid && rsp.ready) begin
				rsp_beats++;
				if (expected_rsp_q.size() == 0) begin
					report_mismatch($sformatf("beat %0d arrived with nothing outstanding",
						rsp_beats));
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.page_out !== want.page_out)
						report_mismatch($sformatf("beat %0d page_out %0d, expected %0d",
							rsp_beats, rsp.page_out, want.page_out));
					if (rsp.status !== want.status)
						report_mismatch($sformatf("beat %0d status %0d, expected %0d",
							rsp_beats, rsp.status, want.status));
					if (rsp.free_pages !== want.free_pages)
						report_mismatch($sformatf("beat %0d free_pages %0d, expected %0d",
							rsp_beats, rsp.free_pages, want.free_pages));
				end
			end
			if (cmd.valid && cmd.ready) begin
				expected_rsp_q.push_back(apply_pool_op(cmd.opcode, cmd.page_in));
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_FIRST_PAGE)
					cfg_first = cfg.data[FIRST_W-1:0];
				else
					cfg_end = cfg.data[END_W-1:0];
			end
			outstanding <= expected_rsp_q.size();
		end
	end

endmodule

[sim/page_free_list_allocator_core_tb.sv]
`timescale 1ns / 1ps

module page_free_list_allocator_core_tb;
	import pfla_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	pfla_cfg_if cfg_if ();
	pfla_cmd_if cmd_if ();
	pfla_rsp_if rsp_if ();

	int unsigned errors;
	int unsigned outstanding;
	bit          quiet;
	int unsigned items_sent;
	int unsigned pool_first = 0;
	int unsigned pool_end   = PAGE_COUNT;
	int unsigned rsp_beats;
	int unsigned hold_left;

	page_free_list_allocator_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	pfla_pool_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_if),
		.cmd         (cmd_if),
		.rsp         (rsp_if),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Receiver: random back-pressure, plus two long hold-offs that let the block
	// fill up and stall the command side.
	always @(posedge clk) begin
		if (rsp_if.valid && rsp_if.ready) begin
			rsp_beats++;
			if (rsp_beats == 300 || rsp_beats == 1300)
				hold_left = 200;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= quiet || ($urandom_range(99) >= 24);
		end
	end

	task automatic issue_cmd(input opcode_t op, input int unsigned pg);
		if (!quiet && $urandom_range(99) < 24) begin
			cmd_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_if.valid   <= 1'b1;
		cmd_if.opcode  <= op;
		cmd_if.page_in <= PAGE_W'(pg);
		@(posedge clk);
		while (!cmd_if.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic drain_pool();
		cmd_if.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= CFG_DATA_W'(value);
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
	endtask

	task automatic set_pool(input int unsigned first_pg, input int unsigned end_pg);
		drain_pool();
		write_reg(CFG_FIRST_PAGE, first_pg);
		write_reg(CFG_END_PAGE, end_pg);
		cfg_if.valid <= 1'b0;
		pool_first = first_pg;
		pool_end   = end_pg;
	endtask

	task automatic pick_pool();
		int unsigned r;
		int unsigned first_pg;
		int unsigned end_pg;
		r = $urandom_range(99);
		first_pg = $urandom_range(PAGE_COUNT - 1);
		if (r < 3) begin
			end_pg = PAGE_COUNT;
		end else if (r < 10) begin
			end_pg = $urandom_range(first_pg);
		end else begin
			end_pg = first_pg + $urandom_range(1, 48);
			if (end_pg > PAGE_COUNT)
				end_pg = PAGE_COUNT;
		end
		set_pool(first_pg, end_pg);
	endtask

	// Mostly allocates and frees inside the pool, so the list keeps filling and
	// draining; the rest is out-of-range frees, stray pages, unused opcodes and inits of small pools.
	task automatic random_cmd();
		int unsigned r;
		int unsigned bound;
		int unsigned span;
		int unsigned pg;
		bound = (pool_end < PAGE_COUNT) ? pool_end : PAGE_COUNT;
		span  = (bound > pool_first) ? bound - pool_first : 0;
		r     = $urandom_range(99);
		pg    = $urandom_range(PAGE_COUNT - 1);
		if (r < 42) begin
			issue_cmd(OP_ALLOC, pg);
		end else if (r < 82) begin
			if (span != 0)
				pg = pool_first + $urandom_range(span - 1);
			issue_cmd(OP_FREE, pg);
		end else if (r < 88) begin
			if (pool_first != 0 && (bound >= PAGE_COUNT || $urandom_range(1) == 0))
				pg = $urandom_range(pool_first - 1);
			else if (bound < PAGE_COUNT)
				pg = $urandom_range(bound, PAGE_COUNT - 1);
			issue_cmd(OP_FREE, pg);
		end else if (r < 94) begin
			issue_cmd(OP_FREE, pg);
		end else if (r < 97) begin
			issue_cmd(OP_NOP, pg);
		end else if (span <= 256) begin
			issue_cmd(OP_INIT, pg);
		end else begin
			issue_cmd(OP_ALLOC, pg);
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		cmd_if.valid   <= 1'b0;
		cmd_if.opcode  <= OP_NOP;
		cmd_if.page_in <= '0;
		cfg_if.valid   <= 1'b0;
		cfg_if.index   <= CFG_FIRST_PAGE;
		cfg_if.data    <= '0;
		quiet          <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Straight out of reset: empty list, a page never allocated, unused opcode.
		issue_cmd(OP_ALLOC, 0);
		issue_cmd(OP_FREE, 5);
		issue_cmd(OP_NOP, PAGE_COUNT - 1);
		// Whole pool, highest page comes out first.
		issue_cmd(OP_INIT, 0);
		issue_cmd(OP_ALLOC, 0);
		issue_cmd(OP_ALLOC, 0);
		issue_cmd(OP_FREE, PAGE_COUNT - 1);
		issue_cmd(OP_FREE, PAGE_COUNT - 1);
		issue_cmd(OP_ALLOC, 0);

		// Single page at the top; the page below keeps its allocation bit.
		set_pool(PAGE_COUNT - 1, PAGE_COUNT);
		issue_cmd(OP_INIT, 0);
		issue_cmd(OP_ALLOC, 0);
		issue_cmd(OP_ALLOC, 0);
		issue_cmd(OP_FREE, PAGE_COUNT - 2);
		issue_cmd(OP_FREE, PAGE_COUNT - 1);
		issue_cmd(OP_FREE, PAGE_COUNT - 1);

		// End below first: init leaves the list empty.
		set_pool(10, 0);
		issue_cmd(OP_INIT, 0);
		issue_cmd(OP_ALLOC, 0);
		issue_cmd(OP_FREE, 10);

		set_pool(5, 9);
		issue_cmd(OP_INIT, 0);
		issue_cmd(OP_ALLOC, 0);
		issue_cmd(OP_ALLOC, 0);
		issue_cmd(OP_ALLOC, 0);
		issue_cmd(OP_FREE, 4);
		issue_cmd(OP_FREE, 9);
		issue_cmd(OP_FREE, 7);

		while (items_sent < 1900) begin
			pick_pool();
			// Some phases keep the old list under the new bounds.
			if ($urandom_range(99) < 85)
				issue_cmd(OP_INIT, $urandom_range(PAGE_COUNT - 1));
			repeat ($urandom_range(30, 90)) begin
				quiet <= (items_sent >= 700 && items_sent < 1000);
				random_cmd();
			end
		end

		quiet <= 1'b0;
		drain_pool();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
